### rtl/stl_pkg.sv
`default_nettype none
package stl_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int MAX_RESULTS = 8;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   typedef enum logic [3:0] {
      M_IDLE,
      M_LINE,
      M_BLOCK,
      M_BTAIL,
      M_IDENT,
      M_NZERO,
      M_NINT,
      M_NFRAC,
      M_NESIGN,
      M_NEXP,
      M_STR,
      M_SESC
   } mode_type;

   typedef enum logic [2:0] {
      K_IDENT,
      K_INT,
      K_FLOAT,
      K_STR,
      K_CHAR,
      K_EOF
   } kind_type;

   typedef enum logic [2:0] {
      REG_LINE_FIRST,
      REG_LINE_SECOND,
      REG_BOPEN_FIRST,
      REG_BOPEN_SECOND,
      REG_BCLOSE_FIRST,
      REG_BCLOSE_SECOND,
      REG_NEWLINE_BLANK
   } reg_index_type;

   typedef logic [1:0] op_idx_type;
   localparam op_idx_type FLUSH_OP = 2'd3;

   // s0..s2 slide as the lexer window; op i lexes s[i] with s[i+1] as lookahead
   typedef struct packed {
      logic [7:0] s0;
      logic [7:0] s1;
      logic [7:0] s2;
      logic [1:0] n_ops;
      logic       flush;
   } op_entry_type;

   typedef struct packed {
      logic [7:0] line_first;
      logic [7:0] line_second;
      logic [7:0] bopen_first;
      logic [7:0] bopen_second;
      logic [7:0] bclose_first;
      logic [7:0] bclose_second;
      logic       newline_blank;
   } cfg_type;

   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_DOT    = 8'h2e;
   localparam logic [7:0] CH_MINUS  = 8'h2d;
   localparam logic [7:0] CH_NL     = 8'h0a;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_E_LO   = 8'h65;
   localparam logic [7:0] CH_E_UP   = 8'h45;
   localparam logic [7:0] CH_N      = 8'h6e;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;

endpackage
`default_nettype wire

### rtl/stl_ifs.sv
`default_nettype none
interface stl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_final;

   modport source (output valid, in_byte, in_final, input ready);
   modport sink (input valid, in_byte, in_final, output ready);
endinterface

interface stl_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [2:0] out_kind;
   logic       has_byte;
   logic       token_close;
   logic       run_last;

   modport source (output valid, out_byte, out_kind, has_byte, token_close, run_last,
                   input ready);
   modport sink (input valid, out_byte, out_kind, has_byte, token_close, run_last,
                 output ready);
endinterface
`default_nettype wire

### rtl/stl_front.sv
`default_nettype none
module stl_front (
   input  logic                  clock,
   input  logic                  reset,
   stl_req_if.sink               req_ch,
   output logic                  q_push,
   output stl_pkg::op_entry_type q_data,
   input  logic                  q_full
);
   import stl_pkg::*;

   logic [7:0]   cur_ff, cur_in;
   logic [7:0]   la_ff, la_in;
   logic [1:0]   fill_ff, fill_in;
   logic         accept;
   logic         flush;
   logic [7:0]   b;
   op_entry_type entry;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign b            = req_ch.in_byte;
   assign flush        = req_ch.in_final || (b == 8'd0);

   always_comb begin
      entry       = '0;
      entry.flush = flush;
      if (b != 8'd0) begin
         case (fill_ff)
            2'd2: begin
               entry.s0    = cur_ff;
               entry.s1    = la_ff;
               entry.s2    = b;
               entry.n_ops = flush ? 2'd3 : 2'd1;
            end
            2'd1: begin
               entry.s0    = cur_ff;
               entry.s1    = b;
               entry.n_ops = flush ? 2'd2 : 2'd0;
            end
            default: begin
               entry.s0    = b;
               entry.n_ops = flush ? 2'd1 : 2'd0;
            end
         endcase
      end else begin
         case (fill_ff)
            2'd2: begin
               entry.s0    = cur_ff;
               entry.s1    = la_ff;
               entry.n_ops = 2'd2;
            end
            2'd1: begin
               entry.s0    = cur_ff;
               entry.n_ops = 2'd1;
            end
            default: entry.n_ops = 2'd0;
         endcase
      end
   end

   always_comb begin
      cur_in  = cur_ff;
      la_in   = la_ff;
      fill_in = fill_ff;
      if (accept) begin
         if (flush) begin
            cur_in  = 8'd0;
            la_in   = 8'd0;
            fill_in = 2'd0;
         end else begin
            case (fill_ff)
               2'd0: begin
                  cur_in  = b;
                  fill_in = 2'd1;
               end
               2'd1: begin
                  la_in   = b;
                  fill_in = 2'd2;
               end
               default: begin
                  cur_in = la_ff;
                  la_in  = b;
               end
            endcase
         end
      end
   end

   assign q_push = accept && ((entry.n_ops != 2'd0) || entry.flush);
   assign q_data = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff  <= 8'd0;
         la_ff   <= 8'd0;
         fill_ff <= 2'd0;
      end else begin
         cur_ff  <= cur_in;
         la_ff   <= la_in;
         fill_ff <= fill_in;
      end
   end

endmodule
`default_nettype wire

### rtl/stl_queue.sv
`default_nettype none
module stl_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  stl_pkg::op_entry_type push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  valid,
   output stl_pkg::op_entry_type head
);
   import stl_pkg::*;

   op_entry_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full    = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign valid   = (count_ff != '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = (QPTR_W + 1)'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = (QPTR_W + 1)'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### rtl/stl_back.sv
`default_nettype none
module stl_back (
   input  logic                  clock,
   input  logic                  reset,
   input  stl_pkg::cfg_type      cfg,
   input  logic                  q_valid,
   input  stl_pkg::op_entry_type q_head,
   output logic                  q_pop,
   stl_rsp_if.source             rsp_ch
);
   import stl_pkg::*;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
             || (c == 8'h5f);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   mode_type             mode_ff, mode_in;
   logic                 hex_ff, hex_in;
   logic                 chr_ff, chr_in;
   op_idx_type           op_idx_ff, op_idx_in;
   logic [RES_CNT_W-1:0] cnt_ff, cnt_in;

   logic                 pend_valid_ff, pend_valid_in;
   logic                 pend_last_ff;
   logic [7:0]           pend_data_ff;
   kind_type             pend_kind_ff;
   logic                 pend_close_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_last_ff;
   logic [7:0]           rsp_data_ff;
   kind_type             rsp_kind_ff;
   logic                 rsp_close_ff;

   op_idx_type           eff_idx;
   op_idx_type           next_idx;
   logic                 more_window;
   logic                 last_op;
   logic [7:0]           c;
   logic [7:0]           nx;

   mode_type             st_mode;
   logic                 st_hex;
   logic                 st_chr;
   logic                 st_emit;
   logic [7:0]           st_data;
   kind_type             st_kind;
   logic                 st_close;
   logic                 st_done;

   logic                 line_hit;
   logic                 block_hit;
   logic                 blank;

   logic                 rsp_free;
   logic                 adv;
   logic                 end_evt;
   logic                 emit_eff;
   logic                 pend_move;

   assign eff_idx     = (q_head.n_ops == 2'd0) ? FLUSH_OP : op_idx_ff;
   assign more_window = ({1'b0, eff_idx} + 3'd1) < {1'b0, q_head.n_ops};
   assign next_idx    = more_window ? op_idx_type'(eff_idx + 1'b1) : FLUSH_OP;
   assign last_op     = (eff_idx == FLUSH_OP) || (!more_window && !q_head.flush);

   always_comb begin
      case (eff_idx)
         2'd0: begin
            c  = q_head.s0;
            nx = q_head.s1;
         end
         2'd1: begin
            c  = q_head.s1;
            nx = q_head.s2;
         end
         2'd2: begin
            c  = q_head.s2;
            nx = 8'd0;
         end
         default: begin
            c  = 8'd0;
            nx = 8'd0;
         end
      endcase
   end

   assign blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR)
                  || ((c == CH_NL) && cfg.newline_blank);
   assign line_hit = (cfg.line_first != 8'd0) && (c == cfg.line_first)
                     && ((cfg.line_second == 8'd0) || (nx == cfg.line_second));
   assign block_hit = (cfg.bopen_first != 8'd0) && (cfg.bopen_second != 8'd0)
                      && (cfg.bclose_first != 8'd0) && (cfg.bclose_second != 8'd0)
                      && (c == cfg.bopen_first) && (nx == cfg.bopen_second);

   // one pass of the scanner loop per cycle when it can advance, at most one result
   always_comb begin
      st_mode  = mode_ff;
      st_hex   = hex_ff;
      st_chr   = 1'b0;
      st_emit  = 1'b0;
      st_data  = c;
      st_kind  = K_CHAR;
      st_close = 1'b0;
      st_done  = 1'b0;
      if (chr_ff) begin
         st_emit  = 1'b1;
         st_close = 1'b1;
         st_done  = 1'b1;
      end else begin
         unique case (mode_ff)
            M_IDLE: begin
               if (c == 8'd0) begin
                  st_emit  = 1'b1;
                  st_kind  = K_EOF;
                  st_close = 1'b1;
                  st_done  = 1'b1;
               end else if (blank) begin
                  st_done = 1'b1;
               end else if (line_hit) begin
                  if (c == CH_NL) begin
                     st_done = 1'b1;
                  end else begin
                     st_mode = M_LINE;
                  end
               end else if (block_hit) begin
                  st_mode = M_BLOCK;
               end else if (is_letter(c)) begin
                  st_emit = 1'b1;
                  st_kind = K_IDENT;
                  st_mode = M_IDENT;
                  st_done = 1'b1;
               end else if (is_digit(c)) begin
                  st_hex = 1'b0;
                  if (c == CH_ZERO) begin
                     st_emit = 1'b1;
                     st_kind = K_INT;
                     st_mode = M_NZERO;
                     st_done = 1'b1;
                  end else begin
                     st_mode = M_NINT;
                  end
               end else if (c == CH_QUOTE) begin
                  st_mode = M_STR;
                  st_done = 1'b1;
               end else begin
                  st_emit = 1'b1;
                  st_chr  = 1'b1;
               end
            end
            M_LINE: begin
               if (c == 8'd0) begin
                  st_mode = M_IDLE;
               end else if (c == CH_NL) begin
                  st_mode = M_IDLE;
                  st_done = (cfg.line_second != 8'd0);
               end else begin
                  st_done = 1'b1;
               end
            end
            M_BLOCK: begin
               if (c == 8'd0) begin
                  st_mode = M_IDLE;
               end else begin
                  if ((c == cfg.bclose_first) && (nx == cfg.bclose_second)) begin
                     st_mode = M_BTAIL;
                  end
                  st_done = 1'b1;
               end
            end
            M_BTAIL: begin
               st_mode = M_IDLE;
               st_done = (c != 8'd0);
            end
            M_IDENT: begin
               st_kind = K_IDENT;
               st_emit = 1'b1;
               if (is_letter(c) || is_digit(c)) begin
                  st_done = 1'b1;
               end else begin
                  st_close = 1'b1;
                  st_mode  = M_IDLE;
               end
            end
            M_NZERO: begin
               st_mode = M_NINT;
               if (c == CH_X) begin
                  st_emit = 1'b1;
                  st_kind = K_INT;
                  st_hex  = 1'b1;
                  st_done = 1'b1;
               end
            end
            M_NINT: begin
               st_emit = 1'b1;
               if (is_digit(c) || (hex_ff && is_hex(c))) begin
                  st_kind = K_INT;
                  st_done = 1'b1;
               end else if (!hex_ff && (c == CH_DOT) && is_digit(nx)) begin
                  st_kind = K_FLOAT;
                  st_mode = M_NFRAC;
                  st_done = 1'b1;
               end else if (!hex_ff && ((c == CH_E_LO) || (c == CH_E_UP))) begin
                  st_kind = K_FLOAT;
                  st_mode = M_NESIGN;
                  st_done = 1'b1;
               end else begin
                  st_kind  = K_INT;
                  st_close = 1'b1;
                  st_mode  = M_IDLE;
               end
            end
            M_NFRAC: begin
               st_emit = 1'b1;
               st_kind = K_FLOAT;
               if (is_digit(c)) begin
                  st_done = 1'b1;
               end else if ((c == CH_E_LO) || (c == CH_E_UP)) begin
                  st_mode = M_NESIGN;
                  st_done = 1'b1;
               end else begin
                  st_close = 1'b1;
                  st_mode  = M_IDLE;
               end
            end
            M_NESIGN: begin
               st_mode = M_NEXP;
               st_kind = K_FLOAT;
               if (c == CH_MINUS) begin
                  st_emit = 1'b1;
                  st_done = 1'b1;
               end
            end
            M_NEXP: begin
               st_emit = 1'b1;
               st_kind = K_FLOAT;
               if (is_digit(c)) begin
                  st_done = 1'b1;
               end else begin
                  st_close = 1'b1;
                  st_mode  = M_IDLE;
               end
            end
            M_STR: begin
               st_kind = K_STR;
               if ((c == 8'd0) || (c == CH_QUOTE)) begin
                  st_emit  = 1'b1;
                  st_close = 1'b1;
                  st_mode  = M_IDLE;
                  st_done  = (c != 8'd0);
               end else if (c == CH_BSLASH) begin
                  st_mode = M_SESC;
                  st_done = 1'b1;
               end else begin
                  st_emit = 1'b1;
                  st_done = 1'b1;
               end
            end
            M_SESC: begin
               st_kind = K_STR;
               st_emit = 1'b1;
               if (c == 8'd0) begin
                  st_close = 1'b1;
                  st_mode  = M_IDLE;
               end else begin
                  if (c == CH_N) begin
                     st_data = CH_NL;
                  end else if (c == CH_R) begin
                     st_data = CH_CR;
                  end else if (c == CH_T) begin
                     st_data = CH_TAB;
                  end
                  st_mode = M_STR;
                  st_done = 1'b1;
               end
            end
            default: begin
               st_mode = M_IDLE;
            end
         endcase
      end
      if (st_close) begin
         st_data = 8'd0;
      end
   end

   // pending slot holds the newest result until it is known whether it is
   // the last one of its item
   assign rsp_free  = !rsp_valid_ff || rsp_ch.ready;
   assign adv       = q_valid && (!pend_valid_ff || rsp_free);
   assign end_evt   = adv && st_done && last_op;
   assign q_pop     = end_evt;
   assign emit_eff  = adv && st_emit && (cnt_ff < RES_CNT_W'(MAX_RESULTS));
   assign pend_move = pend_valid_ff && rsp_free && (pend_last_ff || emit_eff || end_evt);

   always_comb begin
      mode_in   = mode_ff;
      hex_in    = hex_ff;
      chr_in    = chr_ff;
      op_idx_in = op_idx_ff;
      cnt_in    = cnt_ff;
      if (adv) begin
         mode_in = st_mode;
         hex_in  = st_hex;
         chr_in  = st_chr;
         cnt_in  = RES_CNT_W'(cnt_ff + {{(RES_CNT_W-1){1'b0}}, emit_eff});
         if (st_done) begin
            op_idx_in = next_idx;
         end
         if (end_evt) begin
            op_idx_in = '0;
            cnt_in    = '0;
            if (eff_idx == FLUSH_OP) begin
               mode_in = M_IDLE;
               hex_in  = 1'b0;
            end
         end
      end
      pend_valid_in = emit_eff ? 1'b1 : (pend_move ? 1'b0 : pend_valid_ff);
      rsp_valid_in  = pend_move ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= M_IDLE;
         hex_ff        <= 1'b0;
         chr_ff        <= 1'b0;
         op_idx_ff     <= '0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         hex_ff        <= hex_in;
         chr_ff        <= chr_in;
         op_idx_ff     <= op_idx_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_move) begin
         rsp_data_ff  <= pend_data_ff;
         rsp_kind_ff  <= pend_kind_ff;
         rsp_close_ff <= pend_close_ff;
         rsp_last_ff  <= pend_last_ff || (end_evt && !emit_eff);
      end
      if (emit_eff) begin
         pend_data_ff  <= st_data;
         pend_kind_ff  <= st_kind;
         pend_close_ff <= st_close;
         pend_last_ff  <= end_evt;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_byte    = rsp_data_ff;
   assign rsp_ch.out_kind    = rsp_kind_ff;
   assign rsp_ch.has_byte    = !rsp_close_ff;
   assign rsp_ch.token_close = rsp_close_ff;
   assign rsp_ch.run_last    = rsp_last_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= RES_CNT_W'(MAX_RESULTS))
      else $error("result count per item above limit");

   a_chr_idle: assert property (@(posedge clock) disable iff (reset)
      chr_ff |-> (mode_ff == M_IDLE))
      else $error("char token close pending outside idle");

   a_flush_reset: assert property (@(posedge clock) disable iff (reset)
      (end_evt && (eff_idx == FLUSH_OP)) |=> ((mode_ff == M_IDLE) && !hex_ff))
      else $error("scanner state not cleared after end of input");

   a_pend_owner: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && !pend_last_ff) |-> q_valid)
      else $error("open pending result without its item at queue head");

endmodule
`default_nettype wire

### rtl/script_token_lexer_top.sv
// Path: an item goes through the queue; each result goes through the pending slot and
// the response register, and is held until the next result or the item's end is known.
// Throughput: one item per cycle into a 4-entry queue while it is not full; the scanner
// executes one loop step per cycle when it can advance; a char token closes in its own step.
// Reset: synchronous, active high; clears window, queue, scanner and output state
// and loads register defaults.
`default_nettype none
module script_token_lexer_top (
   input  logic       clock,
   input  logic       reset,
   stl_req_if.sink    req_ch,
   stl_rsp_if.source  rsp_ch,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import stl_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         q_push;
   op_entry_type q_data;
   logic         q_full;
   logic         q_valid;
   logic         q_pop;
   op_entry_type q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_LINE_FIRST:    cfg_in.line_first    = csr_wdata;
            REG_LINE_SECOND:   cfg_in.line_second   = csr_wdata;
            REG_BOPEN_FIRST:   cfg_in.bopen_first   = csr_wdata;
            REG_BOPEN_SECOND:  cfg_in.bopen_second  = csr_wdata;
            REG_BCLOSE_FIRST:  cfg_in.bclose_first  = csr_wdata;
            REG_BCLOSE_SECOND: cfg_in.bclose_second = csr_wdata;
            REG_NEWLINE_BLANK: cfg_in.newline_blank = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_first    <= 8'd47;
         cfg_ff.line_second   <= 8'd47;
         cfg_ff.bopen_first   <= 8'd47;
         cfg_ff.bopen_second  <= 8'd42;
         cfg_ff.bclose_first  <= 8'd42;
         cfg_ff.bclose_second <= 8'd47;
         cfg_ff.newline_blank <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   stl_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_push (q_push),
      .q_data (q_data),
      .q_full (q_full)
   );

   stl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   stl_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule
`default_nettype wire
